// ===== hdl/lpg_pkg.sv =====
`timescale 1ns / 1ps

package lpg_pkg;

    localparam int COORD_BITS_DFLT = 12;
    localparam int COLOUR_BITS     = 32;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic is_start;
        logic emit_pixel;
        logic load;
        logic step;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic degenerate;
        logic start_final;
        logic adv_final;
    } t_dp_stat;

endpackage

// ===== hdl/lpg_ifs.sv =====
`timescale 1ns / 1ps

interface lpg_cmd_if
    import lpg_pkg::*;
#(
    parameter int CB = COORD_BITS_DFLT
) ();
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [CB-1:0]          start_x;
    logic [CB-1:0]          start_y;
    logic [CB-1:0]          end_x;
    logic [CB-1:0]          end_y;
    logic [COLOUR_BITS-1:0] colour_in;

    modport source (
        output valid, cmd, start_x, start_y, end_x, end_y, colour_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, start_x, start_y, end_x, end_y, colour_in,
        output ready
    );
endinterface

interface lpg_pix_if
    import lpg_pkg::*;
#(
    parameter int CB = COORD_BITS_DFLT
) ();
    logic                   valid;
    logic                   ready;
    logic [CB-1:0]          pixel_x;
    logic [CB-1:0]          pixel_y;
    logic [COLOUR_BITS-1:0] pixel_colour;
    logic                   pixel_valid;
    logic                   last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_colour, pixel_valid, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_colour, pixel_valid, last,
        output ready
    );
endinterface

// ===== hdl/lpg_ctrl.sv =====
`timescale 1ns / 1ps

module lpg_ctrl
    import lpg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_cmd,
    output logic     o_in_ready,
    input  logic     i_out_ready,
    output logic     o_out_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_dp_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_ACTIVE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_dp_cmd    = '0;
        if (accept) begin
            n_out_valid       = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid       = 1'b0;
        end
        o_dp_cmd.capture  = accept;
        o_dp_cmd.is_start = (i_in_cmd == CMD_START);
        if (accept) begin
            if (i_in_cmd == CMD_START) begin
                // a new line restarts from either state
                o_dp_cmd.load       = !i_stat.degenerate;
                o_dp_cmd.emit_pixel = !i_stat.degenerate;
                n_state = (i_stat.degenerate || i_stat.start_final) ? ST_IDLE : ST_ACTIVE;
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        n_state = ST_IDLE;
                    end
                    ST_ACTIVE: begin
                        o_dp_cmd.step       = 1'b1;
                        o_dp_cmd.emit_pixel = 1'b1;
                        n_state = i_stat.adv_final ? ST_IDLE : ST_ACTIVE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hdl/lpg_datapath.sv =====
`timescale 1ns / 1ps

module lpg_datapath
    import lpg_pkg::*;
#(
    parameter int CB = COORD_BITS_DFLT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [CB-1:0]          i_start_x,
    input  logic [CB-1:0]          i_start_y,
    input  logic [CB-1:0]          i_end_x,
    input  logic [CB-1:0]          i_end_y,
    input  logic [COLOUR_BITS-1:0] i_colour,
    input  t_dp_cmd                i_cmd,
    output t_dp_stat               o_stat,
    output logic [CB-1:0]          o_pixel_x,
    output logic [CB-1:0]          o_pixel_y,
    output logic [COLOUR_BITS-1:0] o_pixel_colour,
    output logic                   o_pixel_valid,
    output logic                   o_last
);

    // line state
    logic [CB-1:0]          r_major, r_minor, r_err, r_den, r_abs_min, r_cnt;
    logic                   r_x_major, r_maj_up, r_min_up;
    logic [COLOUR_BITS-1:0] r_colour;

    // result registers
    logic [CB-1:0]          r_px, r_py;
    logic [COLOUR_BITS-1:0] r_pcol;
    logic                   r_pvalid, r_last;

    // start-side decode
    logic [CB-1:0] ax, ay, s_den, s_abs_min;
    logic          s_x_major, s_maj_up, s_min_up;

    // advance-side arithmetic
    logic [CB:0]   t_sum, t_dif;
    logic [CB-1:0] t_wrap_sum, t_wrap_dif;
    logic          wrap;
    logic [CB-1:0] n_major, n_minor, n_err;

    always_comb begin
        ax        = (i_end_x >= i_start_x) ? i_end_x - i_start_x : i_start_x - i_end_x;
        ay        = (i_end_y >= i_start_y) ? i_end_y - i_start_y : i_start_y - i_end_y;
        s_x_major = (ax >= ay);
        s_den     = s_x_major ? ax : ay;
        s_abs_min = s_x_major ? ay : ax;
        s_maj_up  = s_x_major ? (i_end_x > i_start_x) : (i_end_y > i_start_y);
        s_min_up  = s_x_major ? (i_end_y >= i_start_y) : (i_end_x >= i_start_x);

        o_stat.degenerate  = (ax == '0) && (ay == '0);
        o_stat.start_final = (s_den == CB'(1));
        o_stat.adv_final   = (r_cnt == CB'(1));
    end

    // error term: remainder for a rising minor axis, ceiling slack for a falling one
    always_comb begin
        t_sum      = {1'b0, r_err} + {1'b0, r_abs_min};
        t_dif      = {1'b0, r_err} - {1'b0, r_abs_min};
        t_wrap_sum = t_sum[CB-1:0] - r_den;
        t_wrap_dif = t_dif[CB-1:0] + r_den;
        if (r_min_up) begin
            wrap  = (t_sum >= {1'b0, r_den});
            n_err = wrap ? t_wrap_sum : t_sum[CB-1:0];
        end else begin
            wrap  = t_dif[CB];
            n_err = wrap ? t_wrap_dif : t_dif[CB-1:0];
        end
        n_minor = r_min_up ? r_minor + CB'(wrap) : r_minor - CB'(wrap);
        n_major = r_maj_up ? r_major + CB'(1) : r_major - CB'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_major <= 1'b1;
            r_cnt     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_x_major <= s_x_major;
                r_cnt     <= s_den - CB'(1);
            end else if (i_cmd.step) begin
                r_cnt     <= r_cnt - CB'(1);
            end
        end
        if (i_cmd.load) begin
            r_major   <= s_x_major ? i_start_x : i_start_y;
            r_minor   <= s_x_major ? i_start_y : i_start_x;
            r_err     <= '0;
            r_den     <= s_den;
            r_abs_min <= s_abs_min;
            r_maj_up  <= s_maj_up;
            r_min_up  <= s_min_up;
            r_colour  <= i_colour;
        end else if (i_cmd.step) begin
            r_major   <= n_major;
            r_minor   <= n_minor;
            r_err     <= n_err;
        end
        if (i_cmd.capture) begin
            if (!i_cmd.emit_pixel) begin
                r_px     <= '0;
                r_py     <= '0;
                r_pcol   <= '0;
                r_pvalid <= 1'b0;
                r_last   <= 1'b1;
            end else if (i_cmd.is_start) begin
                r_px     <= i_start_x;
                r_py     <= i_start_y;
                r_pcol   <= i_colour;
                r_pvalid <= 1'b1;
                r_last   <= o_stat.start_final;
            end else begin
                r_px     <= r_x_major ? n_major : n_minor;
                r_py     <= r_x_major ? n_minor : n_major;
                r_pcol   <= r_colour;
                r_pvalid <= 1'b1;
                r_last   <= o_stat.adv_final;
            end
        end
    end

    assign o_pixel_x      = r_px;
    assign o_pixel_y      = r_py;
    assign o_pixel_colour = r_pcol;
    assign o_pixel_valid  = r_pvalid;
    assign o_last         = r_last;

endmodule

// ===== hdl/line_pixel_generator.sv =====
`timescale 1ns / 1ps

// channel   dir  modport  word
// i_cmd     in   sink     cmd, start_x, start_y, end_x, end_y, colour_in
// o_pix     out  source   pixel_x, pixel_y, pixel_colour, pixel_valid, last
//
// one command word in, one pixel word out, one word per clock sustained
// the result sits in an output register; a new word is taken in the same
// cycle the held one leaves, and a stall on o_pix holds i_cmd.ready low
// the minor axis follows an error term updated once per step (add or subtract, then a wrap check)
// synchronous active-low reset returns to idle with no line loaded

module line_pixel_generator
    import lpg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DFLT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpg_cmd_if.sink   i_cmd,
    lpg_pix_if.source o_pix
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    lpg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_in_cmd    (i_cmd.cmd),
        .o_in_ready  (i_cmd.ready),
        .i_out_ready (o_pix.ready),
        .o_out_valid (o_pix.valid),
        .i_stat      (dp_stat),
        .o_dp_cmd    (dp_cmd)
    );

    lpg_datapath #(
        .CB (COORD_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start_x      (i_cmd.start_x),
        .i_start_y      (i_cmd.start_y),
        .i_end_x        (i_cmd.end_x),
        .i_end_y        (i_cmd.end_y),
        .i_colour       (i_cmd.colour_in),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_pixel_x      (o_pix.pixel_x),
        .o_pixel_y      (o_pix.pixel_y),
        .o_pixel_colour (o_pix.pixel_colour),
        .o_pixel_valid  (o_pix.pixel_valid),
        .o_last         (o_pix.last)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lpg_pkg::*;

    localparam int CB           = 12;
    localparam int RANDOM_WORDS = 550;
    localparam int STALL_LIMIT  = 2000;
    localparam int SHOW_MAX     = 10;

    typedef struct packed {
        logic                   cmd;
        logic [CB-1:0]          sx;
        logic [CB-1:0]          sy;
        logic [CB-1:0]          ex;
        logic [CB-1:0]          ey;
        logic [COLOUR_BITS-1:0] colour;
    } t_cmd_word;

    typedef struct packed {
        logic [CB-1:0]          px;
        logic [CB-1:0]          py;
        logic [COLOUR_BITS-1:0] colour;
        logic                   pv;
        logic                   last;
    } t_pix_word;

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // tracks the line being drawn and the pixel words still owed by the block
    class t_line_tracker;
        logic [CB-1:0]          org_x, org_y, tgt_x, tgt_y, major;
        bit                     x_major;
        bit                     active;
        logic [COLOUR_BITS-1:0] colour;
        t_pix_word              owed_pixels[$];
        int                     mismatches, checked, lines, blanks;

        function new();
            org_x = '0;
            org_y = '0;
            tgt_x = '0;
            tgt_y = '0;
            major = '0;
            x_major = 1'b1;
            active = 1'b0;
            colour = '0;
        endfunction

        function t_pix_word blank();
            t_pix_word p;
            p = '0;
            p.last = 1'b1;
            return p;
        endfunction

        // exact minor coordinate: floor(on + k * dmin / dmaj)
        function t_pix_word plot();
            longint om, on, tm, tn, dmaj, dmin, den, num, q, r, minor, nxt;
            t_pix_word p;
            om = x_major ? longint'(org_x) : longint'(org_y);
            on = x_major ? longint'(org_y) : longint'(org_x);
            tm = x_major ? longint'(tgt_x) : longint'(tgt_y);
            tn = x_major ? longint'(tgt_y) : longint'(tgt_x);
            dmaj = tm - om;
            dmin = tn - on;
            den = mag(dmaj);
            if (den == 0) begin
                den = 1;
            end
            num = mag(longint'(major) - om) * mag(dmin);
            q = num / den;
            r = num % den;
            if (dmin >= 0) begin
                minor = on + q;
            end else begin
                minor = on - q - ((r != 0) ? 1 : 0);
            end
            nxt = (dmaj > 0) ? longint'(major) + 1 : longint'(major) - 1;
            p.px = x_major ? major : minor[CB-1:0];
            p.py = x_major ? minor[CB-1:0] : major;
            p.colour = colour;
            p.pv = 1'b1;
            p.last = (nxt == tm);
            if (nxt == tm) begin
                active = 1'b0;
            end
            return p;
        endfunction

        function t_pix_word raster_step(t_cmd_word w);
            longint dx, dy;
            logic [CB-1:0] tm;
            if (w.cmd == CMD_START) begin
                org_x = w.sx;
                org_y = w.sy;
                tgt_x = w.ex;
                tgt_y = w.ey;
                colour = w.colour;
                dx = longint'(tgt_x) - longint'(org_x);
                dy = longint'(tgt_y) - longint'(org_y);
                x_major = (mag(dx) >= mag(dy));
                active = 1'b0;
                lines++;
                if (dx == 0 && dy == 0) begin
                    return blank();
                end
                major = x_major ? org_x : org_y;
                active = 1'b1;
                return plot();
            end
            if (!active) begin
                return blank();
            end
            tm = x_major ? tgt_x : tgt_y;
            if (tm > major) begin
                major = major + CB'(1);
            end else begin
                major = major - CB'(1);
            end
            return plot();
        endfunction

        function void note_command(t_cmd_word w);
            owed_pixels.push_back(raster_step(w));
        endfunction

        function void check_pixel(t_pix_word got);
            t_pix_word want;
            checked++;
            if (!got.pv) begin
                blanks++;
            end
            if (owed_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX) begin
                    $display("[%0t] unexpected pixel word x=%0d y=%0d c=%08h v=%0b l=%0b",
                             $time, got.px, got.py, got.colour, got.pv, got.last);
                end
                return;
            end
            want = owed_pixels.pop_front();
            if (got.px !== want.px || got.py !== want.py || got.colour !== want.colour ||
                got.pv !== want.pv || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= SHOW_MAX) begin
                    $display("[%0t] pixel %0d: exp x=%0d y=%0d c=%08h v=%0b l=%0b",
                             $time, checked, want.px, want.py, want.colour, want.pv,
                             want.last);
                    $display("[%0t] pixel %0d: got x=%0d y=%0d c=%08h v=%0b l=%0b",
                             $time, checked, got.px, got.py, got.colour, got.pv,
                             got.last);
                end
            end
        endfunction

        function int outstanding();
            return owed_pixels.size();
        endfunction
    endclass

    logic          i_clk;
    logic          i_rst_n;
    bit            no_idle;
    int            words_sent;
    int            quiet_cycles;
    t_line_tracker tracker;

    lpg_cmd_if #(.CB(CB)) cmd_if ();
    lpg_pix_if #(.CB(CB)) pix_if ();

    line_pixel_generator #(
        .COORD_BITS(CB)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if.sink),
        .o_pix  (pix_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    // valid stays high across back-to-back words, it only drops for a gap
    task automatic send_word(input t_cmd_word w);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.cmd       <= w.cmd;
        cmd_if.start_x   <= w.sx;
        cmd_if.start_y   <= w.sy;
        cmd_if.end_x     <= w.ex;
        cmd_if.end_y     <= w.ey;
        cmd_if.colour_in <= w.colour;
        do @(posedge i_clk); while (!cmd_if.ready);
        tracker.note_command(w);
        words_sent++;
    endtask

    task automatic start_line(input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                              input logic [CB-1:0] ex, input logic [CB-1:0] ey,
                              input logic [COLOUR_BITS-1:0] col);
        t_cmd_word w;
        w.cmd = CMD_START;
        w.sx = sx;
        w.sy = sy;
        w.ex = ex;
        w.ey = ey;
        w.colour = col;
        send_word(w);
    endtask

    // endpoint fields are junk on an advance, the block must ignore them
    task automatic advance(input int n);
        t_cmd_word w;
        repeat (n) begin
            w.cmd = CMD_ADVANCE;
            w.sx = CB'($urandom);
            w.sy = CB'($urandom);
            w.ex = CB'($urandom);
            w.ey = CB'($urandom);
            w.colour = $urandom;
            send_word(w);
        end
    endtask

    function automatic logic [CB-1:0] near(input logic [CB-1:0] base, input int span);
        int v;
        v = int'(base) + $urandom_range(0, 2 * span) - span;
        if (v < 0) begin
            v = 0;
        end
        if (v > (1 << CB) - 1) begin
            v = (1 << CB) - 1;
        end
        return v[CB-1:0];
    endfunction

    function automatic int steps_of(input logic [CB-1:0] sx, input logic [CB-1:0] sy,
                                    input logic [CB-1:0] ex, input logic [CB-1:0] ey);
        int dx, dy;
        dx = int'(mag(longint'(ex) - longint'(sx)));
        dy = int'(mag(longint'(ey) - longint'(sy)));
        return (dx >= dy) ? dx : dy;
    endfunction

    // output side: random stall before each word
    initial begin
        int stall;
        pix_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                pix_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pix_if.ready <= 1'b1;
            do @(posedge i_clk); while (!pix_if.valid);
        end
    end

    always @(posedge i_clk) begin
        t_pix_word got;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            got.px = pix_if.pixel_x;
            got.py = pix_if.pixel_y;
            got.colour = pix_if.pixel_colour;
            got.pv = pix_if.pixel_valid;
            got.last = pix_if.last;
            tracker.check_pixel(got);
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((cmd_if.valid && cmd_if.ready) || (pix_if.valid && pix_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("line_pixel_generator: mismatch");
                $finish;
            end
        end
    end

    initial begin
        int mode, n, target;
        logic [CB-1:0] sx, sy, ex, ey;
        tracker = new();
        no_idle = 1'b0;
        words_sent = 0;
        i_rst_n <= 1'b0;
        cmd_if.valid <= 1'b0;
        cmd_if.cmd <= CMD_START;
        cmd_if.start_x <= '0;
        cmd_if.start_y <= '0;
        cmd_if.end_x <= '0;
        cmd_if.end_y <= '0;
        cmd_if.colour_in <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // advance with no line loaded
        advance(1);
        // start equals end, nothing to draw
        start_line(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
        advance(1);
        // flat line, run to the end and one past it
        start_line(12'h000, 12'h000, 12'h003, 12'h000, 32'h0000_0000);
        advance(3);
        // steep line across the whole range, abandoned by the next start
        start_line(12'hFFF, 12'h000, 12'hFFC, 12'hFFF, 32'hA5A5_A5A5);
        advance(2);
        // exact diagonal: tie goes to x, y falling
        start_line(12'h000, 12'hFFF, 12'h002, 12'hFFD, 32'h5A5A_5A5A);
        advance(1);
        // single pixel line
        start_line(12'h005, 12'h005, 12'h006, 12'h005, 32'h0123_4567);
        advance(1);
        // y major going down, x falling with a fractional floor
        start_line(12'd100, 12'd50, 12'd97, 12'd43, 32'hFEDC_BA98);
        advance(6);
        target = words_sent + RANDOM_WORDS;

        while (words_sent < target) begin
            if ($urandom_range(0, 5) == 0) begin
                no_idle = !no_idle;
            end
            mode = $urandom_range(0, 19);
            sx = CB'($urandom);
            sy = CB'($urandom);
            if (mode == 0) begin
                advance(1);
            end else if (mode == 1) begin
                start_line(sx, sy, sx, sy, $urandom);
                advance($urandom_range(0, 1));
            end else if (mode <= 3) begin
                // far endpoint, cut short by whatever comes next
                start_line(sx, sy, CB'($urandom), CB'($urandom), $urandom);
                advance($urandom_range(0, 6));
            end else begin
                n = ($urandom_range(0, 9) == 0) ? 150 : 20;
                ex = near(sx, n);
                ey = near(sy, n);
                start_line(sx, sy, ex, ey, $urandom);
                n = steps_of(sx, sy, ex, ey) - 1;
                if (n > 0 && $urandom_range(0, 9) == 0) begin
                    n = $urandom_range(0, n - 1);
                end
                if (n > 0) begin
                    advance(n);
                end
                if ($urandom_range(0, 3) == 0) begin
                    advance(1);
                end
            end
        end
        cmd_if.valid <= 1'b0;

        while (tracker.outstanding() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("%0d command words sent, %0d lines started, %0d pixel words checked",
                 words_sent, tracker.lines, tracker.checked);
        $display("%0d words carried no pixel, %0d mismatches", tracker.blanks,
                 tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("line_pixel_generator: match");
        end else begin
            $display("line_pixel_generator: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/lpg_pkg.sv
hdl/lpg_ifs.sv
hdl/lpg_ctrl.sv
hdl/lpg_datapath.sv
hdl/line_pixel_generator.sv
tb/tb.sv
